/* design/ldpe_pkg.sv */
// Package for the line dash pattern expander: types, constants and codes.
`timescale 1ns / 1ps
package ldpe_pkg;

   localparam int MAX_VERTS = 64;
   localparam int FRAC_BITS = 16;
   localparam int ONE_BITS  = 2 * FRAC_BITS;
   localparam int IDX_W     = $clog2(MAX_VERTS);
   localparam int CNT_W     = $clog2(MAX_VERTS + 1);

   localparam int AR_STEPS  = 33;
   localparam int STEP_W    = $clog2(AR_STEPS + 1);

   localparam logic [1:0] CMD_SOLID   = 2'd0;
   localparam logic [1:0] CMD_DASHED  = 2'd1;
   localparam logic [1:0] CMD_DOTTED  = 2'd2;
   localparam logic [1:0] CMD_DASHDOT = 2'd3;

   localparam logic [2:0] CSR_DASH_GAP_RATIO  = 3'd0;
   localparam logic [2:0] CSR_DOT_GAP_RATIO   = 3'd1;
   localparam logic [2:0] CSR_SCREEN_SCALE    = 3'd2;
   localparam logic [2:0] CSR_PLOTTER_OUTPUT  = 3'd3;
   localparam logic [2:0] CSR_Z_ENABLED       = 3'd4;
   localparam logic [2:0] CSR_MIN_DASH_LENGTH = 3'd5;

   localparam logic [1:0] AR_MUL  = 2'd0;
   localparam logic [1:0] AR_DIV  = 2'd1;
   localparam logic [1:0] AR_SQRT = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] x_start;
      logic signed [31:0] y_start;
      logic signed [31:0] z_start;
      logic signed [31:0] x_end;
      logic signed [31:0] y_end;
      logic signed [31:0] z_end;
      logic [30:0]        dash_length;
      logic               start_endside;
      logic               end_endside;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               visible;
      logic               endside;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        visible;
   } vertex_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [65:0] a;
      logic [32:0] b;
   } ar_cmd_type;

   typedef struct packed {
      logic        done;
      logic [65:0] res;
   } ar_rsp_type;

endpackage

/* design/ldpe_arith.sv */
// Shared arithmetic unit: registered multiply, bit-serial divide and square root.
`timescale 1ns / 1ps
module ldpe_arith import ldpe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ar_cmd_type ar_cmd,
   output ar_rsp_type ar_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [65:0]       res_ff, res_in;
   logic [34:0]       rem_ff, rem_in;
   logic [65:0]       src_ff, src_in;
   logic [32:0]       div_ff, div_in;

   logic [33:0] dv_r2, dv_diff;
   logic        dv_ge;
   logic [36:0] sq_r2, sq_trial, sq_diff;
   logic        sq_ge;

   always_comb begin
      dv_r2    = {rem_ff[32:0], src_ff[65]};
      dv_diff  = dv_r2 - {1'b0, div_ff};
      dv_ge    = dv_r2 >= {1'b0, div_ff};
      sq_r2    = {rem_ff, src_ff[65:64]};
      sq_trial = {2'b00, res_ff[32:0], 2'b01};
      sq_diff  = sq_r2 - sq_trial;
      sq_ge    = sq_r2 >= sq_trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      step_in = step_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      div_in  = div_ff;

      if (ar_cmd.start) begin
         op_in   = ar_cmd.op;
         step_in = STEP_W'(AR_STEPS);
         div_in  = ar_cmd.b;
         case (ar_cmd.op)
            AR_MUL: begin
               res_in  = ar_cmd.a[32:0] * ar_cmd.b;
               done_in = 1'b1;
               busy_in = 1'b0;
            end
            AR_DIV: begin
               res_in  = '0;
               rem_in  = {2'b00, ar_cmd.a[65:33]};
               src_in  = {ar_cmd.a[32:0], 33'd0};
               busy_in = 1'b1;
            end
            default: begin
               res_in  = '0;
               rem_in  = '0;
               src_in  = ar_cmd.a;
               busy_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == AR_DIV) begin
            rem_in = dv_ge ? {2'b00, dv_diff[32:0]} : {2'b00, dv_r2[32:0]};
            res_in = {res_ff[64:0], dv_ge};
            src_in = {src_ff[64:0], 1'b0};
         end else begin
            rem_in = sq_ge ? sq_diff[34:0] : sq_r2[34:0];
            res_in = {res_ff[64:0], sq_ge};
            src_in = {src_ff[63:0], 2'b00};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      div_ff  <= div_in;
   end

   assign ar_rsp.done = done_ff;
   assign ar_rsp.res  = res_ff;

endmodule

/* design/line_dash_pattern_expander_top.sv */
// Top level of the line dash pattern expander: sequencer, vertex buffer and ports.
`timescale 1ns / 1ps
// One line segment is taken at a time; req_stall stays high until its last vertex has
// been loaded into the output register. All arithmetic runs through one shared unit (a
// 33x33 multiplier plus a one-bit-per-cycle divide and square root): the length, the gap
// checks and, for each pattern vertex, three multiply-divide passes, one per axis. Vertices
// collect in a 64-entry buffer and leave one at a time, each read and then loaded into the
// output register, when rsp_stall is low.
module line_dash_pattern_expander_top import ldpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_DIFF  = 5'd1;
   localparam logic [4:0] ST_SQX   = 5'd2;
   localparam logic [4:0] ST_SQY   = 5'd3;
   localparam logic [4:0] ST_ROOT  = 5'd4;
   localparam logic [4:0] ST_CLASS = 5'd5;
   localparam logic [4:0] ST_GAP   = 5'd6;
   localparam logic [4:0] ST_SCHK  = 5'd7;
   localparam logic [4:0] ST_W0    = 5'd8;
   localparam logic [4:0] ST_W1    = 5'd9;
   localparam logic [4:0] ST_STEP  = 5'd10;
   localparam logic [4:0] ST_CHK   = 5'd11;
   localparam logic [4:0] ST_AMUL  = 5'd12;
   localparam logic [4:0] ST_ADIV  = 5'd13;
   localparam logic [4:0] ST_AOUT  = 5'd14;
   localparam logic [4:0] ST_OUTRD = 5'd15;
   localparam logic [4:0] ST_OUTLD = 5'd16;
   localparam logic [4:0] ST_WAIT  = 5'd17;

   logic [15:0] dash_ratio_ff, dot_ratio_ff, min_dash_ff;
   logic [31:0] scale_ff;
   logic        plotter_ff, z_en_ff;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   req_type     in_ff;
   logic [31:0] zs_ff, ze_ff;
   logic [32:0] mag_ff [3];
   logic        neg_ff [3];
   logic [65:0] sum_ff, sum_in;
   logic [32:0] len_ff, len_in;
   logic [32:0] c1_ff, c1_in;
   logic [40:0] c2_ff, c2_in;
   logic        solid_ff, solid_in;
   logic [41:0] dlen_ff, dlen_in;
   logic [1:0]  p_ff, p_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  axis_ff, axis_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   vertex_type  mem [MAX_VERTS];
   vertex_type  rd_ff, wd_c;
   logic        we_c;
   logic [IDX_W-1:0] wa_c;

   ar_cmd_type  ar_cmd;
   ar_rsp_type  ar_rsp;

   logic [32:0] dx_c, dy_c, dz_c;
   logic [31:0] zs_c, ze_c;
   logic [32:0] len_c, c1eff_c;
   logic [40:0] c2_c;
   logic [42:0] short_rhs_c;
   logic        short_c, draw_c, full_c, load_c;
   logic [31:0] start_c, coord_c;
   logic [CNT_W-1:0] half_c;

   ldpe_arith u_arith (
      .clock (clock),
      .reset (reset),
      .ar_cmd(ar_cmd),
      .ar_rsp(ar_rsp)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ratio_ff <= 16'd128;
         dot_ratio_ff  <= 16'd256;
         scale_ff      <= 32'd65536;
         plotter_ff    <= 1'b0;
         z_en_ff       <= 1'b0;
         min_dash_ff   <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DASH_GAP_RATIO:  dash_ratio_ff <= csr_data[15:0];
            CSR_DOT_GAP_RATIO:   dot_ratio_ff  <= csr_data[15:0];
            CSR_SCREEN_SCALE:    scale_ff      <= csr_data;
            CSR_PLOTTER_OUTPUT:  plotter_ff    <= csr_data[0];
            CSR_Z_ENABLED:       z_en_ff       <= csr_data[0];
            CSR_MIN_DASH_LENGTH: min_dash_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      zs_c = z_en_ff ? in_ff.z_start : 32'd0;
      ze_c = z_en_ff ? in_ff.z_end : 32'd0;
      dx_c = {in_ff.x_end[31], in_ff.x_end} - {in_ff.x_start[31], in_ff.x_start};
      dy_c = {in_ff.y_end[31], in_ff.y_end} - {in_ff.y_start[31], in_ff.y_start};
      dz_c = {ze_c[31], ze_c} - {zs_c[31], zs_c};

      len_c   = ar_rsp.res[32:0];
      c1eff_c = {2'b00, in_ff.dash_length};
      if (in_ff.command == CMD_DASHDOT && c1eff_c <= {17'd0, min_dash_ff}) begin
         c1eff_c = len_c;
      end
      c2_c        = ar_rsp.res[48:8];
      short_rhs_c = {10'd0, c1_ff} + {9'd0, c1_ff, 1'b0} + {1'b0, c2_c, 1'b0};
      short_c     = {9'd0, len_ff, 1'b0} < short_rhs_c;

      draw_c = ~p_ff[0];
      full_c = cnt_ff == CNT_W'(MAX_VERTS);
      case (axis_ff)
         2'd0:    start_c = in_ff.x_start;
         2'd1:    start_c = in_ff.y_start;
         default: start_c = zs_ff;
      endcase
      coord_c = neg_ff[axis_ff] ? start_c - ar_rsp.res[31:0] : start_c + ar_rsp.res[31:0];
      half_c  = (cnt_ff - CNT_W'(2)) >> 1;
      load_c  = state_ff == ST_OUTLD && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      solid_in = solid_ff;
      dlen_in  = dlen_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      oidx_in  = oidx_ff;
      ar_cmd   = '0;
      we_c     = 1'b0;
      wa_c     = cnt_ff[IDX_W-1:0];
      wd_c     = {in_ff.x_end, in_ff.y_end, ze_ff, 1'b1};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_SQX;
         ST_SQX: begin
            ar_cmd   = '{start: 1'b1, op: AR_MUL, a: {33'd0, mag_ff[0]}, b: mag_ff[0]};
            ret_in   = ST_SQY;
            state_in = ST_WAIT;
         end
         ST_SQY: begin
            sum_in   = ar_rsp.res;
            ar_cmd   = '{start: 1'b1, op: AR_MUL, a: {33'd0, mag_ff[1]}, b: mag_ff[1]};
            ret_in   = ST_ROOT;
            state_in = ST_WAIT;
         end
         ST_ROOT: begin
            ar_cmd   = '{start: 1'b1, op: AR_SQRT, a: sum_ff + ar_rsp.res, b: 33'd0};
            ret_in   = ST_CLASS;
            state_in = ST_WAIT;
         end
         ST_CLASS: begin
            len_in   = len_c;
            c1_in    = c1eff_c;
            solid_in = in_ff.command == CMD_SOLID || len_c == 33'd0;
            if (in_ff.command == CMD_SOLID || len_c == 33'd0) begin
               state_in = ST_W0;
            end else begin
               ar_cmd = '{start: 1'b1, op: AR_MUL, a: {33'd0, c1eff_c},
                          b: {17'd0, (in_ff.command == CMD_DOTTED) ? dot_ratio_ff
                                                                   : dash_ratio_ff}};
               ret_in   = ST_GAP;
               state_in = ST_WAIT;
            end
         end
         ST_GAP: begin
            c2_in    = c2_c;
            state_in = ST_W0;
            if (in_ff.command != CMD_DASHDOT) begin
               if (short_c || (!plotter_ff && scale_ff == 32'd0)) begin
                  solid_in = 1'b1;
               end else if (!plotter_ff && c2_c[40:33] == 8'd0) begin
                  ar_cmd   = '{start: 1'b1, op: AR_MUL, a: {33'd0, c2_c[32:0]},
                               b: {1'b0, scale_ff}};
                  ret_in   = ST_SCHK;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_SCHK: begin
            if (ar_rsp.res[65:ONE_BITS] == '0) solid_in = 1'b1;
            state_in = ST_W0;
         end
         ST_W0: begin
            we_c     = 1'b1;
            wa_c     = '0;
            wd_c     = {in_ff.x_start, in_ff.y_start, zs_ff, 1'b0};
            cnt_in   = CNT_W'(1);
            dlen_in  = '0;
            p_in     = 2'd0;
            state_in = solid_ff ? ST_W1 : ST_STEP;
         end
         ST_W1: begin
            we_c     = 1'b1;
            cnt_in   = CNT_W'(2);
            oidx_in  = '0;
            state_in = ST_OUTRD;
         end
         ST_STEP: begin
            dlen_in  = dlen_ff + ((p_ff == 2'd0) ? {9'd0, c1_ff} : {1'b0, c2_ff});
            state_in = ST_CHK;
         end
         ST_CHK: begin
            oidx_in = '0;
            if (dlen_ff < {9'd0, len_ff}) begin
               axis_in  = 2'd0;
               state_in = full_c ? ST_OUTRD : ST_AMUL;
            end else begin
               state_in = ST_OUTRD;
               if (draw_c) begin
                  if (!full_c) begin
                     we_c   = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  we_c = 1'b1;
                  wa_c = IDX_W'(cnt_ff - 1'b1);
               end
            end
         end
         ST_AMUL: begin
            ar_cmd   = '{start: 1'b1, op: AR_MUL, a: {33'd0, dlen_ff[32:0]},
                         b: mag_ff[axis_ff]};
            ret_in   = ST_ADIV;
            state_in = ST_WAIT;
         end
         ST_ADIV: begin
            ar_cmd   = '{start: 1'b1, op: AR_DIV, a: ar_rsp.res, b: len_ff};
            ret_in   = ST_AOUT;
            state_in = ST_WAIT;
         end
         ST_AOUT: begin
            case (axis_ff)
               2'd0: begin
                  vx_in    = coord_c;
                  axis_in  = 2'd1;
                  state_in = ST_AMUL;
               end
               2'd1: begin
                  vy_in    = coord_c;
                  axis_in  = 2'd2;
                  state_in = ST_AMUL;
               end
               default: begin
                  we_c     = 1'b1;
                  wd_c     = {vx_ff, vy_ff, coord_c, draw_c};
                  cnt_in   = cnt_ff + 1'b1;
                  p_in     = (in_ff.command == CMD_DASHDOT) ? p_ff + 1'b1
                                                            : {1'b0, ~p_ff[0]};
                  state_in = ST_STEP;
               end
            endcase
         end
         ST_OUTRD: state_in = ST_OUTLD;
         ST_OUTLD: begin
            if (load_c) begin
               oidx_in  = oidx_ff + 1'b1;
               state_in = ({1'b0, oidx_ff} == cnt_ff - 1'b1) ? ST_IDLE : ST_OUTRD;
            end
         end
         ST_WAIT: begin
            if (ar_rsp.done) state_in = ret_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (load_c) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      ret_ff   <= ret_in;
      sum_ff   <= sum_in;
      len_ff   <= len_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      solid_ff <= solid_in;
      dlen_ff  <= dlen_in;
      p_ff     <= p_in;
      axis_ff  <= axis_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      oidx_ff  <= oidx_in;
      if (state_ff == ST_IDLE && req_valid) in_ff <= req_data;
      if (state_ff == ST_DIFF) begin
         zs_ff     <= zs_c;
         ze_ff     <= ze_c;
         mag_ff[0] <= dx_c[32] ? -dx_c : dx_c;
         mag_ff[1] <= dy_c[32] ? -dy_c : dy_c;
         mag_ff[2] <= dz_c[32] ? -dz_c : dz_c;
         neg_ff[0] <= dx_c[32];
         neg_ff[1] <= dy_c[32];
         neg_ff[2] <= dz_c[32];
      end
      if (load_c) begin
         rsp_ff.vert_x  <= rd_ff.x;
         rsp_ff.vert_y  <= rd_ff.y;
         rsp_ff.vert_z  <= rd_ff.z;
         rsp_ff.visible <= rd_ff.visible;
         rsp_ff.endside <= ({1'b0, oidx_ff} <= half_c) ? in_ff.start_endside
                                                       : in_ff.end_endside;
         rsp_ff.last    <= {1'b0, oidx_ff} == cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we_c) mem[wa_c] <= wd_c;
      rd_ff <= mem[oidx_ff];
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input transfer did not start work");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VERTS))
      else $error("vertex count beyond buffer");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      ar_rsp.done |-> state_ff == ST_WAIT)
      else $error("arithmetic result with no waiting step");

endmodule

/* test/line_dash_pattern_expander_top_tb.sv */
// Testbench for the line dash pattern expander: predicted vertex lists checked per transfer.
`timescale 1ns / 1ps
module line_dash_pattern_expander_top_tb;
   import ldpe_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [15:0] dash_ratio, dot_ratio, min_dash;
   logic [31:0] scale;
   logic        plotter, z_on;

   rsp_type     vert_queue[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          idling_on = 1'b1;

   line_dash_pattern_expander_top i_dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [65:0] s);
      logic [65:0] r;
      logic [65:0] b;
      r = 0;
      for (int i = 32; i >= 0; i--) begin
         b = r | (66'd1 << i);
         if (b * b <= s) r = b;
      end
      return r[63:0];
   endfunction

   function automatic logic signed [31:0] along(logic signed [33:0] st, logic signed [33:0] dl,
                                               logic [63:0] d, logic [63:0] len);
      logic [33:0]  mag;
      logic [127:0] q;
      mag = (dl < 0) ? -dl : dl;
      q = ({64'd0, d} * {94'd0, mag}) / {64'd0, len};
      return (dl < 0) ? 32'(st - q[33:0]) : 32'(st + q[33:0]);
   endfunction

   task automatic expand_line(req_type r);
      logic signed [33:0] xs, ys, zs, xe, ye, ze, dx, dy, dz;
      logic [65:0] sum;
      logic [63:0] len, c1, c2, dlen;
      logic [63:0] seg[4];
      bit          draw[4];
      int          nseg, p, cnt, half;
      bit          solid;
      rsp_type     v[$];
      rsp_type     o;
      xs = r.x_start; ys = r.y_start; xe = r.x_end; ye = r.y_end;
      zs = z_on ? 34'(r.z_start) : 34'sd0;
      ze = z_on ? 34'(r.z_end) : 34'sd0;
      dx = xe - xs; dy = ye - ys; dz = ze - zs;
      sum = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
      len = int_sqrt(sum);
      c1 = r.dash_length; c2 = 0; nseg = 2; p = 0;
      solid = (r.command == CMD_SOLID) || (len == 0);
      if (!solid && (r.command == CMD_DASHED || r.command == CMD_DOTTED)) begin
         c2 = (c1 * (r.command == CMD_DASHED ? dash_ratio : dot_ratio)) >> 8;
         if (2 * len < 3 * c1 + 2 * c2) solid = 1;
         if (!plotter) begin
            if (scale == 0) solid = 1;
            else if ({64'd0, c2} * scale < (128'd1 << ONE_BITS)) solid = 1;
         end
         seg[0] = c1; draw[0] = 1; seg[1] = c2; draw[1] = 0;
      end else if (!solid) begin
         if (c1 <= min_dash) c1 = len;
         c2 = (c1 * dash_ratio) >> 8;
         seg[0] = c1; draw[0] = 1; seg[1] = c2; draw[1] = 0;
         seg[2] = c2; draw[2] = 1; seg[3] = c2; draw[3] = 0; nseg = 4;
      end
      o = '0;
      o.vert_x = xs[31:0]; o.vert_y = ys[31:0]; o.vert_z = zs[31:0];
      v.push_back(o);
      o.vert_x = xe[31:0]; o.vert_y = ye[31:0]; o.vert_z = ze[31:0]; o.visible = 1'b1;
      if (solid) v.push_back(o);
      else begin
         dlen = 0;
         forever begin
            dlen += seg[p];
            if (dlen < len) begin
               if (v.size() >= MAX_VERTS) break;
               o.vert_x = along(xs, dx, dlen, len);
               o.vert_y = along(ys, dy, dlen, len);
               o.vert_z = along(zs, dz, dlen, len);
               o.visible = draw[p];
               v.push_back(o);
               p = (p + 1) % nseg;
            end else begin
               o.vert_x = xe[31:0]; o.vert_y = ye[31:0]; o.vert_z = ze[31:0];
               o.visible = 1'b1;
               if (draw[p]) begin
                  if (v.size() < MAX_VERTS) v.push_back(o);
               end else v[v.size() - 1] = o;
               break;
            end
         end
      end
      cnt = v.size();
      half = (cnt - 2) / 2;
      for (int j = 0; j < cnt; j++) begin
         v[j].endside = (j <= half) ? r.start_endside : r.end_endside;
         v[j].last = (j == cnt - 1);
         vert_queue.push_back(v[j]);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vert_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected vertex %p", rsp_data);
         end else begin
            if (rsp_data !== vert_queue[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("vertex mismatch: expected %p actual %p", vert_queue[0], rsp_data);
            end
            void'(vert_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!rsp_stall && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 12);
      end else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DASH_GAP_RATIO:  dash_ratio = val[15:0];
         CSR_DOT_GAP_RATIO:   dot_ratio = val[15:0];
         CSR_SCREEN_SCALE:    scale = val;
         CSR_PLOTTER_OUTPUT:  plotter = val[0];
         CSR_Z_ENABLED:       z_on = val[0];
         CSR_MIN_DASH_LENGTH: min_dash = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (vert_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_line(req_type r);
      if (idling_on && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(posedge clock);
      req_valid <= 1'b1; req_data <= r;
      do @(posedge clock); while (req_stall);
      expand_line(r);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_line(logic [1:0] cmd, int span);
      req_type r;
      r = '0;
      r.command = cmd;
      r.x_start = $urandom; r.y_start = $urandom; r.z_start = $urandom;
      r.x_end = r.x_start + $signed($urandom_range(0, span)) - span / 2;
      r.y_end = r.y_start + $signed($urandom_range(0, span)) - span / 2;
      r.z_end = $urandom;
      r.dash_length = 31'($urandom_range(1, span / 8 + 1));
      r.start_endside = 1'($urandom); r.end_endside = 1'($urandom);
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      for (int c = 0; c < 4; c++) begin
         r = '0; r.command = c[1:0];
         send_line(r);
         r.x_start = 32'h8000_0000; r.y_start = 32'h8000_0000; r.z_start = 32'h8000_0000;
         r.x_end = 32'h7fff_ffff; r.y_end = 32'h7fff_ffff; r.z_end = 32'h7fff_ffff;
         r.dash_length = 31'h7fff_ffff; r.start_endside = 1'b1; r.end_endside = 1'b0;
         send_line(r);
         r.dash_length = 31'h0004_0000;
         send_line(r);
         r.x_start = 32'h7fff_ffff; r.y_start = 32'h7fff_ffff; r.z_start = 32'h7fff_ffff;
         r.x_end = 32'h8000_0000; r.y_end = 32'h8000_0000; r.z_end = 32'h8000_0000;
         r.dash_length = 31'h0000_0001; r.start_endside = 1'b0; r.end_endside = 1'b1;
         send_line(r);
         r = make_line(c[1:0], 32'h0040_0000);
         r.dash_length = 31'h0001_0000;
         send_line(r);
      end
   endtask

   task automatic test_random(int n, int span);
      for (int i = 0; i < n; i++) send_line(make_line(2'($urandom), span));
   endtask

   task automatic test_settings(logic [15:0] dr, logic [15:0] tr, logic [31:0] sc,
                                logic pl, logic zo, logic [15:0] md, int n);
      wait_drained();
      write_reg(CSR_DASH_GAP_RATIO, {16'($urandom), dr});
      write_reg(CSR_DOT_GAP_RATIO, {16'($urandom), tr});
      write_reg(CSR_SCREEN_SCALE, sc);
      write_reg(CSR_PLOTTER_OUTPUT, {31'($urandom), pl});
      write_reg(CSR_Z_ENABLED, {31'($urandom), zo});
      write_reg(CSR_MIN_DASH_LENGTH, {16'($urandom), md});
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
      test_random(n, 32'h0100_0000);
      test_random(n / 4, 32'h0008_0000);
   endtask

   initial begin
      dash_ratio = 128; dot_ratio = 256; scale = 65536; plotter = 0; z_on = 0; min_dash = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(40, 32'h0100_0000);
      test_settings(16'hffff, 16'hffff, 32'hffff_ffff, 1'b1, 1'b1, 16'hffff, 40);
      test_settings(16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, 16'h0000, 40);
      test_settings(16'h0080, 16'h0100, 32'h0001_0000, 1'b1, 1'b0, 16'h0001, 40);
      test_settings(16'h0040, 16'h0200, 32'h0000_0100, 1'b0, 1'b1, 16'h8000, 40);
      test_settings(16'h0100, 16'h0080, 32'h0100_0000, 1'b1, 1'b1, 16'h0010, 40);
      idling_on = 1'b0;
      test_random(40, 32'h0100_0000);
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && vert_queue.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
